// ===== hw/rtl/vpw_pkg.sv =====
`default_nettype none

package vpw_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] MODE_LOAD_MV = 2'd0;
  localparam logic [1:0] MODE_LOAD_PJ = 2'd1;
  localparam logic [1:0] MODE_PROJECT = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] REG_VP_X = 2'd0;
  localparam logic [1:0] REG_VP_Y = 2'd1;
  localparam logic [1:0] REG_VP_W = 2'd2;
  localparam logic [1:0] REG_VP_H = 2'd3;

  localparam logic [13:0] VP_W_RESET = 14'd640;
  localparam logic [13:0] VP_H_RESET = 14'd480;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
    logic signed [31:0] win_z;
  } out_t;

  typedef struct packed {
    logic acc_clr;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MV,
    ST_PJ,
    ST_DIV,
    ST_MAP1,
    ST_MAP2,
    ST_RES
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vertex_project_to_window.sv =====
// vertex_project_to_window: object point -> window coordinates.
// in channel (in_valid/in_stall/in_data): one request per item. Mode load
//   modelview / load projection writes one column-major Q16.16 element;
//   mode project sends an object point (w = 1).
// out channel (out_valid/out_stall/out_data): one result per request. ok is
//   1 for loads and good projections, 0 when clip w is zero (or mode 3);
//   window fields are zero unless a projection succeeds.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): viewport x, y,
//   width, height; always ready, write only while the block is idle.
// One request at a time. A load goes from accept straight to the result state.
// A projection runs two matrix passes (4 row lanes, one multiply per lane
// per cycle); if clip w is nonzero, three parallel restoring dividers at
// one bit per cycle then give the Q16.16 NDC point, and the viewport steps
// MAP1 and MAP2 turn it into Q16.16 window coordinates before the result
// state. A new request is taken only after the last result has left the
// result state.
// in_stall is high while a request is in flight; a finished result waits
// in the output register while out_stall is high.
// Reset clears both matrices to zero and loads the viewport defaults.
`default_nettype none

module vertex_project_to_window #(
  parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire vpw_pkg::in_t in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output vpw_pkg::out_t    out_data,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire [1:0]        cfg_index,
  input  wire [15:0]       cfg_data
);

  localparam int DW  = 32 + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  vpw_pkg::state_t state, state_next;

  // matrices, [row][col]
  logic signed [31:0] mv [4][4];
  logic signed [31:0] pj [4][4];

  logic signed [14:0] vp_x;
  logic signed [14:0] vp_y;
  logic [13:0]        vp_w;
  logic [13:0]        vp_h;

  logic [2:0]         cnt;
  logic [DCW-1:0]     dcnt;
  logic signed [31:0] vec [4];
  logic signed [31:0] lane_res [4];
  logic signed [31:0] ndc [3];
  logic signed [47:0] pmx;
  logic signed [47:0] pmy;
  logic signed [32:0] zsum;
  vpw_pkg::out_t      res;

  vpw_pkg::mac_ctrl_t mac_ctrl;
  vpw_pkg::div_ctrl_t div_ctrl;
  logic               accept;
  logic               out_free;
  logic               pass_end;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign pass_end  = (cnt == 3'd5);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      vpw_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.mode == vpw_pkg::MODE_PROJECT) ?
                       vpw_pkg::ST_MV : vpw_pkg::ST_RES;
        end
      end
      vpw_pkg::ST_MV: begin
        if (pass_end) state_next = vpw_pkg::ST_PJ;
      end
      vpw_pkg::ST_PJ: begin
        if (pass_end) begin
          state_next = (lane_res[3] == 32'sd0) ? vpw_pkg::ST_RES : vpw_pkg::ST_DIV;
        end
      end
      vpw_pkg::ST_DIV: begin
        if (dcnt == DCW'(DW - 1)) state_next = vpw_pkg::ST_MAP1;
      end
      vpw_pkg::ST_MAP1: state_next = vpw_pkg::ST_MAP2;
      vpw_pkg::ST_MAP2: state_next = vpw_pkg::ST_RES;
      vpw_pkg::ST_RES: begin
        if (out_free) state_next = vpw_pkg::ST_IDLE;
      end
      default: state_next = vpw_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall       = 1'b1;
    mac_ctrl       = '0;
    div_ctrl       = '0;
    unique case (state)
      vpw_pkg::ST_IDLE: begin
        in_stall         = 1'b0;
        mac_ctrl.acc_clr = 1'b1;
      end
      vpw_pkg::ST_MV, vpw_pkg::ST_PJ: begin
        mac_ctrl.mul_en  = (cnt < 3'd4);
        mac_ctrl.acc_en  = (cnt >= 3'd1) && (cnt <= 3'd4);
        mac_ctrl.acc_clr = pass_end;
        div_ctrl.start   = pass_end && (state == vpw_pkg::ST_PJ);
      end
      vpw_pkg::ST_DIV: div_ctrl.step = 1'b1;
      vpw_pkg::ST_MAP1, vpw_pkg::ST_MAP2, vpw_pkg::ST_RES: begin
      end
      default: begin
      end
    endcase
  end

  // matrix row lanes
  for (genvar i = 0; i < 4; i++) begin : g_mac
    logic signed [31:0] coeff;
    assign coeff = (state == vpw_pkg::ST_MV) ? mv[i][cnt[1:0]] : pj[i][cnt[1:0]];
    vpw_mac_lane #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clk     (clk),
      .ctrl    (mac_ctrl),
      .coeff   (coeff),
      .operand (vec[cnt[1:0]]),
      .result  (lane_res[i])
    );
  end

  // divider lanes for x, y, z
  for (genvar k = 0; k < 3; k++) begin : g_div
    vpw_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk  (clk),
      .ctrl (div_ctrl),
      .num  (lane_res[k]),
      .den  (lane_res[3]),
      .quot (ndc[k])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vpw_pkg::ST_IDLE;
      cnt       <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
      vp_x      <= '0;
      vp_y      <= '0;
      vp_w      <= vpw_pkg::VP_W_RESET;
      vp_h      <= vpw_pkg::VP_H_RESET;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mv[r][c] <= '0;
          pj[r][c] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          vpw_pkg::REG_VP_X: vp_x <= cfg_data[14:0];
          vpw_pkg::REG_VP_Y: vp_y <= cfg_data[14:0];
          vpw_pkg::REG_VP_W: vp_w <= cfg_data[13:0];
          vpw_pkg::REG_VP_H: vp_h <= cfg_data[13:0];
          default: begin
          end
        endcase
      end
      if (accept && in_data.mode == vpw_pkg::MODE_LOAD_MV) begin
        mv[in_data.elem_index[1:0]][in_data.elem_index[3:2]] <= in_data.elem_value;
      end
      if (accept && in_data.mode == vpw_pkg::MODE_LOAD_PJ) begin
        pj[in_data.elem_index[1:0]][in_data.elem_index[3:2]] <= in_data.elem_value;
      end
      if ((state == vpw_pkg::ST_MV || state == vpw_pkg::ST_PJ) && !pass_end) begin
        cnt <= cnt + 3'd1;
      end else begin
        cnt <= '0;
      end
      if (state == vpw_pkg::ST_DIV) begin
        dcnt <= dcnt + DCW'(1);
      end else begin
        dcnt <= '0;
      end
      if (state == vpw_pkg::ST_RES && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      vec[0] <= in_data.obj_x;
      vec[1] <= in_data.obj_y;
      vec[2] <= in_data.obj_z;
      vec[3] <= ONE;
      res    <= '{ok: (in_data.mode == vpw_pkg::MODE_LOAD_MV) ||
                      (in_data.mode == vpw_pkg::MODE_LOAD_PJ),
                  win_x: '0, win_y: '0, win_z: '0};
    end
    // merge: lanes -> eye, then clip vector
    if ((state == vpw_pkg::ST_MV || state == vpw_pkg::ST_PJ) && pass_end) begin
      for (int i = 0; i < 4; i++) vec[i] <= lane_res[i];
      res <= '0;
    end
    if (state == vpw_pkg::ST_MAP1) begin
      pmx  <= 48'(33'(ONE) + 33'(ndc[0])) * 48'($signed({1'b0, vp_w}));
      pmy  <= 48'(33'(ONE) + 33'(ndc[1])) * 48'($signed({1'b0, vp_h}));
      zsum <= 33'(ONE) + 33'(ndc[2]);
    end
    if (state == vpw_pkg::ST_MAP2) begin
      res <= '{ok: 1'b1,
               win_x: vpw_pkg::sat32((64'(vp_x) <<< FRAC_BITS) + (64'(pmx) >>> 1)),
               win_y: vpw_pkg::sat32((64'(vp_y) <<< FRAC_BITS) + (64'(pmy) >>> 1)),
               win_z: vpw_pkg::sat32(64'(zsum) >>> 1)};
    end
    if (state == vpw_pkg::ST_RES && out_free) begin
      out_data <= res;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != vpw_pkg::ST_IDLE)
    else $error("accepted request did not start work");

  a_res_holds: assert property (@(posedge clk) disable iff (rst)
    (state == vpw_pkg::ST_RES && !out_free) |=> state == vpw_pkg::ST_RES)
    else $error("result dropped while output busy");

  a_out_from_res: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == vpw_pkg::ST_RES)
    else $error("output raised outside result state");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == vpw_pkg::ST_DIV |-> vec[3] != 32'sd0)
    else $error("divide started with zero clip w");

endmodule

`default_nettype wire

// ===== hw/rtl/vpw_mac_lane.sv =====
`default_nettype none

// One matrix row: one multiply per cycle, floor shift, exact accumulate.
module vpw_mac_lane #(
  parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF
) (
  input  wire                      clk,
  input  wire vpw_pkg::mac_ctrl_t  ctrl,
  input  wire logic signed [31:0]  coeff,
  input  wire logic signed [31:0]  operand,
  output logic signed [31:0]       result
);

  localparam int ACC_W = 66 - FRAC_BITS;

  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [63:0]      shifted;

  assign shifted = prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= 64'(coeff) * 64'(operand);
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + shifted[ACC_W-1:0];
    end
  end

  assign result = vpw_pkg::sat32(64'(acc));

endmodule

`default_nettype wire

// ===== hw/rtl/vpw_div_lane.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
module vpw_div_lane #(
  parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF
) (
  input  wire                      clk,
  input  wire vpw_pkg::div_ctrl_t  ctrl,
  input  wire logic signed [31:0]  num,
  input  wire logic signed [31:0]  den,
  output logic signed [31:0]       quot
);

  localparam int DW = 32 + FRAC_BITS;

  logic [31:0]        rem;
  logic [DW-1:0]      qs;
  logic [31:0]        dmag;
  logic               neg;
  logic signed [32:0] num_ext;
  logic signed [32:0] den_ext;
  logic [32:0]        num_abs;
  logic [32:0]        den_abs;
  logic [32:0]        rsh;
  logic signed [DW:0] qv;

  assign num_ext = 33'(num);
  assign den_ext = 33'(den);
  assign num_abs = num[31] ? 33'(-num_ext) : 33'(num_ext);
  assign den_abs = den[31] ? 33'(-den_ext) : 33'(den_ext);
  assign rsh     = {rem, qs[DW-1]};

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem  <= '0;
      qs   <= {num_abs[31:0], {FRAC_BITS{1'b0}}};
      dmag <= den_abs[31:0];
      neg  <= num[31] ^ den[31];
    end else if (ctrl.step) begin
      if (rsh >= {1'b0, dmag}) begin
        rem <= 32'(rsh - {1'b0, dmag});
        qs  <= {qs[DW-2:0], 1'b1};
      end else begin
        rem <= rsh[31:0];
        qs  <= {qs[DW-2:0], 1'b0};
      end
    end
  end

  assign qv   = neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
  assign quot = vpw_pkg::sat32(64'(qv));

endmodule

`default_nettype wire

// ===== sim/vertex_project_to_window_tb.sv =====
`default_nettype none

module vertex_project_to_window_tb;

  localparam int FRAC = vpw_pkg::FRAC_BITS_DEF;
  // cycles with no request moving on any channel before we give up
  localparam int STUCK_LIMIT = 4000;
  // idle rate per side, in percent
  localparam int IDLE_PCT = 38;

  typedef longint vec4_t[4];
  typedef logic signed [31:0] mat_t[16];

  // Scoreboard: keeps its own copy of both matrices and the viewport,
  // predicts the window point of each accepted request, checks in order.
  class projection_tracker;
    mat_t modelview;
    mat_t projection;
    logic signed [14:0] vp_x;
    logic signed [14:0] vp_y;
    logic [13:0] vp_w;
    logic [13:0] vp_h;
    vpw_pkg::out_t expected_windows[$];
    int fails;

    function new();
      foreach (modelview[i]) begin
        modelview[i] = '0;
        projection[i] = '0;
      end
      vp_x = '0;
      vp_y = '0;
      vp_w = vpw_pkg::VP_W_RESET;
      vp_h = vpw_pkg::VP_H_RESET;
      fails = 0;
    endfunction

    function void set_viewport(logic [1:0] idx, logic [15:0] val);
      case (idx)
        vpw_pkg::REG_VP_X: vp_x = val[14:0];
        vpw_pkg::REG_VP_Y: vp_y = val[14:0];
        vpw_pkg::REG_VP_W: vp_w = val[13:0];
        vpw_pkg::REG_VP_H: vp_h = val[13:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // each product floored by FRAC, row sum saturated
    function vec4_t transform(mat_t m, vec4_t v);
      vec4_t res;
      longint acc;
      for (int row = 0; row < 4; row++) begin
        acc = 0;
        for (int col = 0; col < 4; col++)
          acc += (longint'(m[col*4+row]) * v[col]) >>> FRAC;
        res[row] = clamp32(acc);
      end
      return res;
    endfunction

    function vpw_pkg::out_t project_request(vpw_pkg::in_t r);
      vpw_pkg::out_t res;
      vec4_t obj;
      vec4_t eye;
      vec4_t clip;
      longint ndc[3];
      longint one;
      longint wx;
      longint wy;
      longint wz;
      res = '0;
      one = 64'sd1 <<< FRAC;
      case (r.mode)
        vpw_pkg::MODE_LOAD_MV: begin
          modelview[r.elem_index] = r.elem_value;
          res.ok = 1'b1;
        end
        vpw_pkg::MODE_LOAD_PJ: begin
          projection[r.elem_index] = r.elem_value;
          res.ok = 1'b1;
        end
        vpw_pkg::MODE_PROJECT: begin
          obj[0] = longint'(r.obj_x);
          obj[1] = longint'(r.obj_y);
          obj[2] = longint'(r.obj_z);
          obj[3] = one;
          eye = transform(modelview, obj);
          clip = transform(projection, eye);
          if (clip[3] != 0) begin
            for (int k = 0; k < 3; k++)
              ndc[k] = clamp32((clip[k] * one) / clip[3]);
            wx = longint'(vp_x) * one + (((one + ndc[0]) * longint'(vp_w)) >>> 1);
            wy = longint'(vp_y) * one + (((one + ndc[1]) * longint'(vp_h)) >>> 1);
            wz = (one + ndc[2]) >>> 1;
            res.ok = 1'b1;
            res.win_x = 32'(clamp32(wx));
            res.win_y = 32'(clamp32(wy));
            res.win_z = 32'(clamp32(wz));
          end
        end
        default: ;  // mode 3: no state change, ok low
      endcase
      return res;
    endfunction

    function void note(vpw_pkg::in_t r);
      expected_windows.push_back(project_request(r));
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fails++;
    endtask

    task check(vpw_pkg::out_t got);
      vpw_pkg::out_t want;
      if (expected_windows.size() == 0) begin
        report("unexpected result, ok", got.ok, -1);
        return;
      end
      want = expected_windows.pop_front();
      if (got.ok !== want.ok) report("ok", got.ok, want.ok);
      if (got.win_x !== want.win_x) report("win_x", got.win_x, want.win_x);
      if (got.win_y !== want.win_y) report("win_y", got.win_y, want.win_y);
      if (got.win_z !== want.win_z) report("win_z", got.win_z, want.win_z);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  vpw_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vpw_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = vpw_pkg::REG_VP_X;
  logic [15:0] cfg_data = '0;

  // no idling on either side while set
  bit quiet = 1'b0;
  int stuck_cycles = 0;
  projection_tracker tracker;

  vertex_project_to_window dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function bit idle_roll();
    return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // signed value in [-2^bits, 2^bits]
  function logic signed [31:0] rand_q(int bits);
    return $signed($urandom_range(0, 2 ** (bits + 1))) - (2 ** bits);
  endfunction

  function vpw_pkg::in_t noise_request();
    vpw_pkg::in_t r;
    r.mode = 2'($urandom_range(0, 3));
    r.elem_index = 4'($urandom_range(0, 15));
    r.elem_value = $urandom;
    r.obj_x = $urandom;
    r.obj_y = $urandom;
    r.obj_z = $urandom;
    return r;
  endfunction

  function vpw_pkg::in_t load_request(logic [1:0] mode, int idx, logic signed [31:0] val);
    vpw_pkg::in_t r;
    r = noise_request();  // unused fields stay random
    r.mode = mode;
    r.elem_index = 4'(idx);
    r.elem_value = val;
    return r;
  endfunction

  function vpw_pkg::in_t point_request(logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z);
    vpw_pkg::in_t r;
    r = noise_request();
    r.mode = vpw_pkg::MODE_PROJECT;
    r.obj_x = x;
    r.obj_y = y;
    r.obj_z = z;
    return r;
  endfunction

  // Sender: valid rises at a falling edge after a random gap and holds until
  // the block takes the request at a rising edge with in_stall low.
  task issue_request(vpw_pkg::in_t r);
    @(negedge clk);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    tracker.note(r);
  endtask

  // Sender holds off until every expected result is back.
  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called after drain(), so the block is idle.
  task write_viewport(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_viewport(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task set_viewport_all(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                        logic [15:0] h);
    drain();
    write_viewport(vpw_pkg::REG_VP_X, x);
    write_viewport(vpw_pkg::REG_VP_Y, y);
    write_viewport(vpw_pkg::REG_VP_W, w);
    write_viewport(vpw_pkg::REG_VP_H, h);
  endtask

  // Mostly well-formed runs: a burst of element loads with moderate values,
  // then a handful of points; the rest is full-range noise.
  task random_phase(int n_items);
    int issued;
    int n_loads;
    int n_points;
    logic [1:0] which;
    issued = 0;
    while (issued < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        n_loads = $urandom_range(1, 16);
        for (int i = 0; i < n_loads; i++) begin
          which = $urandom_range(0, 1) ? vpw_pkg::MODE_LOAD_PJ : vpw_pkg::MODE_LOAD_MV;
          issue_request(load_request(which, $urandom_range(0, 15),
                                     rand_q($urandom_range(12, 19))));
        end
        n_points = $urandom_range(1, 8);
        for (int i = 0; i < n_points; i++)
          issue_request(point_request(rand_q(22), rand_q(22), rand_q(22)));
        issued += n_loads + n_points;
      end else begin
        issue_request(noise_request());
        issued++;
      end
      if ($urandom_range(0, 99) < 3) drain();
    end
  endtask

  // Receiver stall changes only at falling edges.
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= idle_roll();
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) tracker.check(out_data);
    end
  end

  // Watchdog on forward progress of any channel.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
          || rst) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero matrices give clip w zero, then mode 3.
    issue_request(point_request(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    issue_request(load_request(vpw_pkg::MODE_NONE, 5, 32'sh0001_0000));
    // identity modelview and projection
    for (int d = 0; d < 4; d++) begin
      issue_request(load_request(vpw_pkg::MODE_LOAD_MV, d * 5, 32'sh0001_0000));
      issue_request(load_request(vpw_pkg::MODE_LOAD_PJ, d * 5, 32'sh0001_0000));
    end
    issue_request(point_request(0, 0, 0));
    issue_request(point_request(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
    issue_request(point_request(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    // huge translation saturates the eye row sum
    issue_request(load_request(vpw_pkg::MODE_LOAD_MV, 12, 32'sh7FFF_FFFF));
    issue_request(point_request(32'sh7FFF_FFFF, 0, 0));
    issue_request(load_request(vpw_pkg::MODE_LOAD_MV, 12, 32'sh8000_0000));
    issue_request(point_request(32'sh8000_0000, 0, 0));
    // tiny clip w: divide saturates
    issue_request(load_request(vpw_pkg::MODE_LOAD_PJ, 15, 32'sh0000_0001));
    issue_request(point_request(32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000));
    // clip w zero with loaded matrices
    issue_request(load_request(vpw_pkg::MODE_LOAD_PJ, 15, 32'sh0000_0000));
    issue_request(point_request(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
    // negative w
    issue_request(load_request(vpw_pkg::MODE_LOAD_PJ, 15, 32'sh8000_0000));
    issue_request(point_request(32'sh0003_0000, 32'shFFFD_0000, 32'sh0001_8000));

    // Random phases across viewport settings, extremes included.
    random_phase(450);
    set_viewport_all(16'h4000, 16'h3FFF, 16'h3FFF, 16'h0000);
    quiet = 1'b1;  // full-rate stretch
    random_phase(300);
    quiet = 1'b0;
    random_phase(150);
    set_viewport_all(16'h3FFF, 16'h4000, 16'h0000, 16'h3FFF);
    random_phase(450);
    set_viewport_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(450);

    drain();
    repeat (80) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
